FILE: hw/rtl/imu_bcc_pkg.sv
package imu_bcc_pkg;

  // Opcode of an input item
  localparam logic OpSample = 1'b0;
  localparam logic OpStart  = 1'b1;

  // Width of the gravity register and its value after reset
  localparam int unsigned GravW = 15;
  localparam logic [GravW-1:0] GravityReset = 15'd8192;

  // One input item
  typedef struct packed {
    logic               opcode;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] gyro_z_raw;
  } sample_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] accel_x_fixed;
    logic signed [15:0] accel_y_fixed;
    logic signed [15:0] accel_z_fixed;
    logic signed [15:0] gyro_x_fixed;
    logic signed [15:0] gyro_y_fixed;
    logic signed [15:0] gyro_z_fixed;
    logic               calibrating;
  } result_t;

endpackage

FILE: hw/rtl/imu_bcc_stream_if.sv
// Valid/ready channel carrying one item of type T
interface imu_bcc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/imu_bias_calibrate_and_correct.sv
// A sample's result is in the output buffer from the cycle after the sample is accepted.
// One item per cycle unless the offset unit is busy or the two-entry output buffer is full.
// The sample that completes a calibration stalls input while the offset unit (one
// multiplier, reciprocal of SAMPLES) turns the sums of each finished calibration into offsets.
// Reset (async, active low): calibrations idle, counts/sums/offsets zero,
// gravity_counts 8192, output buffer empty.
module imu_bias_calibrate_and_correct #(
  parameter int unsigned SAMPLES = 100
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            gravity_we_i,
  input  logic [imu_bcc_pkg::GravW-1:0]   gravity_wdata_i,
  imu_bcc_stream_if.sink                  sample_i,
  imu_bcc_stream_if.source                result_o
);

  // Widths derived from SAMPLES
  localparam int unsigned C   = $clog2(SAMPLES);
  localparam int unsigned MW  = 16 + C;          // sum magnitude
  localparam int unsigned SW  = MW + 1;          // signed sum
  localparam int unsigned CW  = $clog2(SAMPLES + 2);
  localparam int unsigned K   = MW + C;          // reciprocal shift
  localparam int unsigned PW  = 2 * MW + 1;      // product width
  localparam logic [63:0] KPow = 64'd1 << K;
  localparam logic [63:0] Recip = (KPow + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [MW:0] RecipM = Recip[MW:0];
  localparam logic [CW-1:0] LastCount = CW'(SAMPLES);
  localparam logic [2:0] AxisAccZ = 3'd2;
  localparam logic [2:0] AxisGyrX = 3'd3;
  localparam logic [2:0] AxisLast = 3'd5;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // State
  logic [imu_bcc_pkg::GravW-1:0] grav_q;
  logic                 acc_busy_q, acc_busy_d, gyr_busy_q, gyr_busy_d;
  logic [CW-1:0]        acc_cnt_q, acc_cnt_d, gyr_cnt_q, gyr_cnt_d;
  logic signed [SW-1:0] acc_sum_q [3];
  logic signed [SW-1:0] acc_sum_d [3];
  logic signed [SW-1:0] gyr_sum_q [3];
  logic signed [SW-1:0] gyr_sum_d [3];
  logic signed [16:0]   acc_off_q [3];
  logic signed [16:0]   acc_off_d [3];
  logic signed [15:0]   gyr_off_q [3];
  logic signed [15:0]   gyr_off_d [3];

  // Offset unit
  logic              div_busy_q, iss_q, fin_acc_q, fin_gyr_q;
  logic [2:0]        iss_idx_q;
  logic              s1_vld_q, s1_neg_q, s2_vld_q, s2_neg_q;
  logic [2:0]        s1_idx_q, s2_idx_q;
  logic [MW-1:0]     s1_mag_q;
  logic [PW-1:0]     s2_prod_q;

  // Output buffer
  imu_bcc_pkg::result_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]           cnt_q, cnt_d;

  // ---------------------------------------------------------------------
  // Correction of the incoming readings
  logic signed [15:0] raw   [6];
  logic signed [15:0] fixed [6];
  imu_bcc_pkg::result_t res;
  logic accept, push, pop, fin_acc, fin_gyr;

  assign raw[0] = sample_i.data.accel_x_raw;
  assign raw[1] = sample_i.data.accel_y_raw;
  assign raw[2] = sample_i.data.accel_z_raw;
  assign raw[3] = sample_i.data.gyro_x_raw;
  assign raw[4] = sample_i.data.gyro_y_raw;
  assign raw[5] = sample_i.data.gyro_z_raw;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fixed[i]   = sat16(18'(raw[i]) - 18'(acc_off_q[i]));
      fixed[3+i] = sat16(18'(raw[3+i]) - 18'(gyr_off_q[i]));
    end
  end

  assign sample_i.ready = !div_busy_q && (cnt_q != 2'd2);
  assign accept = sample_i.valid && sample_i.ready;
  assign push   = accept && (sample_i.data.opcode == imu_bcc_pkg::OpSample);
  assign pop    = result_o.valid && result_o.ready;

  // Offset unit: quotient of the stage-2 product, signed
  logic [15:0]        q_mag;
  logic signed [16:0] q_sgn;
  assign q_mag = s2_prod_q[K +: 16];
  assign q_sgn = s2_neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  // Calibration sequencing per item, plus offset writes from the unit
  always_comb begin
    acc_busy_d = acc_busy_q;
    gyr_busy_d = gyr_busy_q;
    acc_cnt_d  = acc_cnt_q;
    gyr_cnt_d  = gyr_cnt_q;
    acc_sum_d  = acc_sum_q;
    gyr_sum_d  = gyr_sum_q;
    acc_off_d  = acc_off_q;
    gyr_off_d  = gyr_off_q;
    fin_acc    = 1'b0;
    fin_gyr    = 1'b0;

    if (accept && sample_i.data.opcode == imu_bcc_pkg::OpStart) begin
      acc_busy_d = 1'b1;
      gyr_busy_d = 1'b1;
    end else if (push) begin
      if (acc_busy_q && acc_cnt_q == '0) begin
        // first accel sample: clear, gyro waits this sample
        for (int i = 0; i < 3; i++) begin
          acc_off_d[i] = '0;
          acc_sum_d[i] = '0;
        end
        acc_cnt_d = CW'(1);
      end else begin
        if (acc_busy_q) begin
          for (int i = 0; i < 3; i++) begin
            acc_sum_d[i] = acc_sum_q[i] + SW'(fixed[i]);
          end
          if (acc_cnt_q == LastCount) begin
            acc_cnt_d  = '0;
            acc_busy_d = 1'b0;
            fin_acc    = 1'b1;
          end else begin
            acc_cnt_d = acc_cnt_q + CW'(1);
          end
        end
        if (gyr_busy_q) begin
          if (gyr_cnt_q == '0) begin
            for (int i = 0; i < 3; i++) begin
              gyr_off_d[i] = '0;
              gyr_sum_d[i] = '0;
            end
            gyr_cnt_d = CW'(1);
          end else begin
            for (int i = 0; i < 3; i++) begin
              gyr_sum_d[i] = gyr_sum_q[i] + SW'(fixed[3+i]);
            end
            if (gyr_cnt_q == LastCount) begin
              gyr_cnt_d  = '0;
              gyr_busy_d = 1'b0;
              fin_gyr    = 1'b1;
            end else begin
              gyr_cnt_d = gyr_cnt_q + CW'(1);
            end
          end
        end
      end
    end

    // offset write from the unit (input is stalled meanwhile)
    if (s2_vld_q) begin
      if (s2_idx_q < AxisGyrX) begin
        if (fin_acc_q) begin
          acc_off_d[s2_idx_q[1:0]] = (s2_idx_q == AxisAccZ) ?
                                     q_sgn - $signed({2'b00, grav_q}) : q_sgn;
        end
      end else if (fin_gyr_q) begin
        gyr_off_d[2'(s2_idx_q - AxisGyrX)] = q_sgn[15:0];
      end
    end
  end

  // Result of the current item
  always_comb begin
    res.accel_x_fixed = fixed[0];
    res.accel_y_fixed = fixed[1];
    res.accel_z_fixed = fixed[2];
    res.gyro_x_fixed  = fixed[3];
    res.gyro_y_fixed  = fixed[4];
    res.gyro_z_fixed  = fixed[5];
    res.calibrating   = acc_busy_d || gyr_busy_d;
  end

  // Two-entry output buffer, slot0 is the head
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q + {1'b0, push} - {1'b0, pop};
    if (pop) begin
      slot0_d = (cnt_q == 2'd2) ? slot1_q : res;
      slot1_d = res;
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        slot0_d = res;
      end else begin
        slot1_d = res;
      end
    end
  end

  assign result_o.valid = (cnt_q != 2'd0);
  assign result_o.data  = slot0_q;

  // Sum selected for the offset unit
  logic signed [SW-1:0] sel_sum;
  logic [SW-1:0]        sel_neg;
  assign sel_sum = (iss_idx_q < AxisGyrX) ? acc_sum_q[iss_idx_q[1:0]]
                                          : gyr_sum_q[2'(iss_idx_q - AxisGyrX)];
  assign sel_neg = -sel_sum;

  // ---------------------------------------------------------------------
  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q     <= imu_bcc_pkg::GravityReset;
      acc_busy_q <= 1'b0;
      gyr_busy_q <= 1'b0;
      acc_cnt_q  <= '0;
      gyr_cnt_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        acc_sum_q[i] <= '0;
        gyr_sum_q[i] <= '0;
        acc_off_q[i] <= '0;
        gyr_off_q[i] <= '0;
      end
      cnt_q      <= 2'd0;
      div_busy_q <= 1'b0;
      iss_q      <= 1'b0;
      iss_idx_q  <= 3'd0;
      fin_acc_q  <= 1'b0;
      fin_gyr_q  <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
    end else begin
      if (gravity_we_i) begin
        grav_q <= gravity_wdata_i;
      end
      acc_busy_q <= acc_busy_d;
      gyr_busy_q <= gyr_busy_d;
      acc_cnt_q  <= acc_cnt_d;
      gyr_cnt_q  <= gyr_cnt_d;
      acc_sum_q  <= acc_sum_d;
      gyr_sum_q  <= gyr_sum_d;
      acc_off_q  <= acc_off_d;
      gyr_off_q  <= gyr_off_d;
      cnt_q      <= cnt_d;

      // offset unit control
      if (fin_acc || fin_gyr) begin
        div_busy_q <= 1'b1;
        iss_q      <= 1'b1;
        iss_idx_q  <= 3'd0;
        fin_acc_q  <= fin_acc;
        fin_gyr_q  <= fin_gyr;
      end else begin
        if (iss_q) begin
          iss_idx_q <= iss_idx_q + 3'd1;
          if (iss_idx_q == AxisLast) begin
            iss_q <= 1'b0;
          end
        end
        if (s2_vld_q && s2_idx_q == AxisLast) begin
          div_busy_q <= 1'b0;
        end
      end
      s1_vld_q <= iss_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  // Payload registers: output slots and offset unit datapath
  always_ff @(posedge clk_i) begin
    slot0_q   <= slot0_d;
    slot1_q   <= slot1_d;
    s1_idx_q  <= iss_idx_q;
    s1_neg_q  <= sel_sum[SW-1];
    s1_mag_q  <= sel_sum[SW-1] ? sel_neg[MW-1:0] : sel_sum[MW-1:0];
    s2_idx_q  <= s1_idx_q;
    s2_neg_q  <= s1_neg_q;
    s2_prod_q <= PW'(s1_mag_q) * PW'(RecipM);
  end

  // ---------------------------------------------------------------------
  // Assertions
  a_stall_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> !sample_i.ready)
    else $error("input taken while offsets are computed");

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_fin_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_acc || fin_gyr) |=> (div_busy_q && iss_q && iss_idx_q == 3'd0))
    else $error("finished calibration did not start the offset unit");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_idx_q == AxisLast) |=> !div_busy_q)
    else $error("offset unit did not release input");

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CalLen      = 100;     // samples averaged per calibration
  localparam int SettleCycles = 24;     // margin for the offset unit to finish after the last item
  localparam int HoldAt      = 400;     // item count at which the long result stall starts
  localparam int HoldCycles  = 60;
  localparam int CycleLimit  = 300000;

  // One row of the directed table: the item, and the expected result when it is
  // just the raw readings passed through (offsets still zero)
  typedef struct packed {
    logic        op;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] gz;
    logic        typed;
    logic        cal;
  } dir_row_t;

  localparam dir_row_t DirTab [17] = '{
    // after reset: no offsets, no calibration
    '{imu_bcc_pkg::OpSample, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      1'b1, 1'b0},
    '{imu_bcc_pkg::OpSample, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
      1'b1, 1'b0},
    '{imu_bcc_pkg::OpSample, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
      1'b1, 1'b0},
    '{imu_bcc_pkg::OpSample, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
      1'b1, 1'b0},
    '{imu_bcc_pkg::OpSample, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
      1'b1, 1'b0},
    '{imu_bcc_pkg::OpSample, 16'h0001, 16'h8001, 16'h7ffe, 16'haaaa, 16'h5555, 16'h0100,
      1'b1, 1'b0},
    // start: no result, raw fields are don't-care
    '{imu_bcc_pkg::OpStart,  16'h7fff, 16'h8000, 16'hffff, 16'h1234, 16'h5555, 16'haaaa,
      1'b0, 1'b0},
    // accel takes its first step, gyro waits
    '{imu_bcc_pkg::OpSample, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
      1'b1, 1'b1},
    // gyro takes its first step
    '{imu_bcc_pkg::OpSample, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
      1'b1, 1'b1},
    // start while running keeps the counts
    '{imu_bcc_pkg::OpStart,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      1'b0, 1'b0},
    '{imu_bcc_pkg::OpSample, 16'h1234, 16'hedcb, 16'h2000, 16'hfedc, 16'h0042, 16'h8001,
      1'b1, 1'b1},
    '{imu_bcc_pkg::OpSample, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
      1'b1, 1'b1},
    '{imu_bcc_pkg::OpSample, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
      1'b1, 1'b1},
    '{imu_bcc_pkg::OpSample, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
      1'b1, 1'b1},
    '{imu_bcc_pkg::OpStart,  16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
      1'b0, 1'b0},
    '{imu_bcc_pkg::OpSample, 16'h0fff, 16'hf000, 16'h3c3c, 16'hc3c3, 16'h00ff, 16'hff00,
      1'b0, 1'b0},
    '{imu_bcc_pkg::OpSample, 16'h7000, 16'h9000, 16'h6000, 16'ha000, 16'h4000, 16'hc000,
      1'b0, 1'b0}
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              gravity_we_i;
  logic [imu_bcc_pkg::GravW-1:0]     gravity_wdata_i;

  imu_bcc_stream_if #(.T(imu_bcc_pkg::sample_t)) sample_if ();
  imu_bcc_stream_if #(.T(imu_bcc_pkg::result_t)) result_if ();

  imu_bias_calibrate_and_correct #(
    .SAMPLES (CalLen)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gravity_we_i    (gravity_we_i),
    .gravity_wdata_i (gravity_wdata_i),
    .sample_i        (sample_if),
    .result_o        (result_if)
  );

  // Mirror of the calibration state
  logic [imu_bcc_pkg::GravW-1:0] grav_q = imu_bcc_pkg::GravityReset;
  bit               acc_run = 1'b0;
  bit               gyr_run = 1'b0;
  int               acc_cnt = 0;
  int               gyr_cnt = 0;
  int               acc_sum [3] = '{0, 0, 0};
  int               gyr_sum [3] = '{0, 0, 0};
  int               acc_off [3] = '{0, 0, 0};
  int               gyr_off [3] = '{0, 0, 0};

  imu_bcc_pkg::result_t corrected_q [$];   // corrected readings still to come out
  int               err_cnt = 0;
  int               items_in = 0;
  int               cycle_cnt = 0;
  int               bias [6];          // center of the random readings per axis

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Correct one sample and advance both calibrations; returns 1 if a result is due
  function automatic bit correct_and_track(input imu_bcc_pkg::sample_t s,
                                           output imu_bcc_pkg::result_t r);
    int raw [6];
    int fixd [6];
    bit gyro_waits;
    r = '0;
    gyro_waits = 1'b0;
    if (s.opcode == imu_bcc_pkg::OpStart) begin
      acc_run = 1'b1;
      gyr_run = 1'b1;
      return 1'b0;
    end
    raw[0] = int'($signed(s.accel_x_raw));
    raw[1] = int'($signed(s.accel_y_raw));
    raw[2] = int'($signed(s.accel_z_raw));
    raw[3] = int'($signed(s.gyro_x_raw));
    raw[4] = int'($signed(s.gyro_y_raw));
    raw[5] = int'($signed(s.gyro_z_raw));
    for (int i = 0; i < 3; i++) begin
      fixd[i]     = sat16(raw[i] - acc_off[i]);
      fixd[3 + i] = sat16(raw[3 + i] - gyr_off[i]);
    end

    // accel calibration: clear on the first step, then sum and average
    if (acc_run) begin
      if (acc_cnt == 0) begin
        for (int i = 0; i < 3; i++) begin
          acc_off[i] = 0;
          acc_sum[i] = 0;
        end
        acc_cnt = 1;
        gyro_waits = 1'b1;
      end else begin
        acc_cnt++;
        for (int i = 0; i < 3; i++) acc_sum[i] += fixd[i];
        if (acc_cnt == CalLen + 1) begin
          for (int i = 0; i < 3; i++) acc_off[i] = acc_sum[i] / CalLen;
          acc_off[2] -= int'(grav_q);
          acc_cnt = 0;
          acc_run = 1'b0;
        end
      end
    end

    // gyro calibration: same, no gravity, sits out the accel's first step
    if (gyr_run && !gyro_waits) begin
      if (gyr_cnt == 0) begin
        for (int i = 0; i < 3; i++) begin
          gyr_off[i] = 0;
          gyr_sum[i] = 0;
        end
        gyr_cnt = 1;
      end else begin
        gyr_cnt++;
        for (int i = 0; i < 3; i++) gyr_sum[i] += fixd[3 + i];
        if (gyr_cnt == CalLen + 1) begin
          for (int i = 0; i < 3; i++) gyr_off[i] = gyr_sum[i] / CalLen;
          gyr_cnt = 0;
          gyr_run = 1'b0;
        end
      end
    end

    r.accel_x_fixed = fixd[0][15:0];
    r.accel_y_fixed = fixd[1][15:0];
    r.accel_z_fixed = fixd[2][15:0];
    r.gyro_x_fixed  = fixd[3][15:0];
    r.gyro_y_fixed  = fixd[4][15:0];
    r.gyro_z_fixed  = fixd[5][15:0];
    r.calibrating   = acc_run || gyr_run;
    return 1'b1;
  endfunction

  function automatic void pick_biases();
    foreach (bias[i]) begin
      case ($urandom_range(0, 3))
        0:       bias[i] = 32000;
        1:       bias[i] = -32000;
        2:       bias[i] = 0;
        default: bias[i] = int'($urandom_range(0, 65535)) - 32768;
      endcase
    end
  endfunction

  // Mostly noisy readings around a per-axis bias, some wild values, a few starts
  function automatic imu_bcc_pkg::sample_t random_item();
    imu_bcc_pkg::sample_t s;
    int      v [6];
    s = imu_bcc_pkg::sample_t'({$urandom, $urandom, $urandom, $urandom});
    s.opcode = imu_bcc_pkg::OpSample;
    if ($urandom_range(0, 99) < 3) begin
      s.opcode = imu_bcc_pkg::OpStart;
      return s;
    end
    if ($urandom_range(0, 149) == 0) pick_biases();
    foreach (v[i]) begin
      case ($urandom_range(0, 9))
        7, 8:    v[i] = int'($urandom_range(0, 65535)) - 32768;
        9:       v[i] = $urandom_range(0, 1) ? 32767 : -32768;
        default: v[i] = sat16(bias[i] + int'($urandom_range(0, 1023)) - 512);
      endcase
    end
    s.accel_x_raw = v[0][15:0];
    s.accel_y_raw = v[1][15:0];
    s.accel_z_raw = v[2][15:0];
    s.gyro_x_raw  = v[3][15:0];
    s.gyro_y_raw  = v[4][15:0];
    s.gyro_z_raw  = v[5][15:0];
    return s;
  endfunction

  // Offer one item and hold it until accepted; fixed_res replaces the prediction when typed is set
  task automatic push_item(input imu_bcc_pkg::sample_t s, input bit typed,
                           input imu_bcc_pkg::result_t fixed_res);
    imu_bcc_pkg::result_t r;
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    if (correct_and_track(s, r)) corrected_q.push_back(typed ? fixed_res : r);
    items_in++;
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      sample_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic run_random(input int n);
    int burst;
    burst = $urandom_range(1, 30);
    repeat (n) begin
      push_item(random_item(), 1'b0, '0);
      burst--;
      if (burst == 0) begin
        idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst = $urandom_range(1, 60);
      end
    end
  endtask

  // Change gravity only once the block has drained and the offset unit settled
  task automatic set_gravity(input logic [imu_bcc_pkg::GravW-1:0] g);
    sample_if.valid <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    gravity_we_i    <= 1'b1;
    gravity_wdata_i <= g;
    @(posedge clk_i);
    grav_q = g;
    gravity_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    imu_bcc_pkg::result_t got;
    imu_bcc_pkg::result_t want;
    if (result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (corrected_q.size() == 0) begin
        $error("result with no item pending");
        err_cnt++;
      end else begin
        want = corrected_q.pop_front();
        check_field("accel_x_fixed", int'(want.accel_x_fixed), int'(got.accel_x_fixed));
        check_field("accel_y_fixed", int'(want.accel_y_fixed), int'(got.accel_y_fixed));
        check_field("accel_z_fixed", int'(want.accel_z_fixed), int'(got.accel_z_fixed));
        check_field("gyro_x_fixed", int'(want.gyro_x_fixed), int'(got.gyro_x_fixed));
        check_field("gyro_y_fixed", int'(want.gyro_y_fixed), int'(got.gyro_y_fixed));
        check_field("gyro_z_fixed", int'(want.gyro_z_fixed), int'(got.gyro_z_fixed));
        check_field("calibrating", int'(want.calibrating), int'(got.calibrating));
      end
    end
  end

  // Result side stalls in stretches of varying density, plus one long hold-off
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        if (!held && items_in >= HoldAt) begin
          held = 1'b1;
          result_if.ready <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          0:       result_if.ready <= 1'b1;
          1:       result_if.ready <= 1'($urandom_range(0, 1));
          2:       result_if.ready <= ($urandom_range(0, 7) == 0);
          default: result_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // Main sequence
  initial begin
    imu_bcc_pkg::sample_t s;
    imu_bcc_pkg::result_t want;
    rst_ni          <= 1'b0;
    gravity_we_i    <= 1'b0;
    gravity_wdata_i <= '0;
    sample_if.valid <= 1'b0;
    sample_if.data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items, gravity at its reset value
    foreach (DirTab[i]) begin
      s.opcode      = DirTab[i].op;
      s.accel_x_raw = DirTab[i].ax;
      s.accel_y_raw = DirTab[i].ay;
      s.accel_z_raw = DirTab[i].az;
      s.gyro_x_raw  = DirTab[i].gx;
      s.gyro_y_raw  = DirTab[i].gy;
      s.gyro_z_raw  = DirTab[i].gz;
      want.accel_x_fixed = DirTab[i].ax;
      want.accel_y_fixed = DirTab[i].ay;
      want.accel_z_fixed = DirTab[i].az;
      want.gyro_x_fixed  = DirTab[i].gx;
      want.gyro_y_fixed  = DirTab[i].gy;
      want.gyro_z_fixed  = DirTab[i].gz;
      want.calibrating   = DirTab[i].cal;
      push_item(s, DirTab[i].typed, want);
    end

    // random phases over several gravity settings
    pick_biases();
    run_random(200);
    set_gravity('0);
    pick_biases();
    run_random(250);
    set_gravity({imu_bcc_pkg::GravW{1'b1}});
    pick_biases();
    run_random(250);
    set_gravity(imu_bcc_pkg::GravW'($urandom_range(1, 32766)));
    pick_biases();
    run_random(250);

    // drain
    sample_if.valid <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/imu_bcc_pkg.sv
hw/rtl/imu_bcc_stream_if.sv
hw/rtl/imu_bias_calibrate_and_correct.sv
tb/tb.sv
